// File: design/sat_pkg.sv
// sat_pkg: constants, types and codes for the sorted adjacency table
// no dependencies
`default_nettype none
package sat_pkg;
    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 16;
    localparam int SLOTS      = MAX_NODES * MAX_DEGREE;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int DEG_W      = $clog2(MAX_DEGREE);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int NCNT_W     = $clog2(MAX_NODES + 1);
    localparam int ECNT_W     = $clog2(SLOTS + 1);
    localparam int DCNT_W     = $clog2(MAX_DEGREE + 1);
    localparam int DIST_W     = 32;

    typedef enum logic [1:0] {
        ACT_ADD_NODE = 2'd0,
        ACT_ADD_EDGE = 2'd1,
        ACT_MODIFY   = 2'd2,
        ACT_LOOKUP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_LIST_FULL = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NODE_FULL = 3'd4
    } status_t;

    // shared memory port request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_sink;
        logic [DIST_W-1:0] wr_dist;
    } mem_req_t;
endpackage
`default_nettype wire

// File: design/sat_ram.sv
// sat_ram: generic single-write, single-read RAM with registered read
// no dependencies
`default_nettype none
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: design/sat_edge_mem.sv
// sat_edge_mem: edge slot storage (sink id and distance per slot)
// depends on sat_pkg and sat_ram
`default_nettype none
module sat_edge_mem (
    input  wire logic                     aclk,
    input  wire sat_pkg::mem_req_t        req,
    output logic      [sat_pkg::NODE_W-1:0] rd_sink,
    output logic      [sat_pkg::DIST_W-1:0] rd_dist
);
    import sat_pkg::*;

    // sink id column
    sat_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_sink_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_sink),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (rd_sink)
    );

    // distance column
    sat_ram #(.WIDTH(DIST_W), .DEPTH(SLOTS)) u_dist_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_dist),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (rd_dist)
    );
endmodule
`default_nettype wire

// File: design/sorted_adjacency_table_core.sv
// sorted_adjacency_table_core: top level, sequencer for search, shift and insert
// depends on sat_pkg, sat_edge_mem and sat_ram
//
// channel  | direction | signals
// ---------+-----------+------------------------------------------------
// s_       | in        | s_valid/s_ready, action, source, sink, distance
// m_       | out       | m_valid/m_ready, one result per input transfer
// cfg      | in        | cfg_wr_en/cfg_wr_data, allow_multi_edges
//
// add node and bad ids go straight to the result; lookup/modify run a binary search,
// one read of the shared edge memory port per search step, up to 5 steps;
// add edge adds a second search in multi mode and a read and a write per shifted
// entry of the tail. one item at a time.
// reset clears the counts; a node's degree entry is written when the node is added.
// a result held by m_ready low keeps s_ready low.
`default_nettype none
module sorted_adjacency_table_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_action,
    input  wire logic [sat_pkg::NODE_W-1:0]   s_source_node,
    input  wire logic [sat_pkg::NODE_W-1:0]   s_sink_node,
    input  wire logic signed [31:0]           s_edge_distance,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [2:0]                        m_status,
    output logic [sat_pkg::DEG_W-1:0]         m_position,
    output logic [sat_pkg::NODE_W-1:0]        m_new_node_id,
    output logic                              m_edge_found,
    output logic signed [31:0]                m_found_distance,
    output logic [sat_pkg::NCNT_W-1:0]        m_node_total,
    output logic [sat_pkg::ECNT_W-1:0]        m_edge_total,
    output logic [sat_pkg::DCNT_W-1:0]        m_out_degree
);
    import sat_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SRCH   = 9'b000000010,
        S_SWAIT  = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_HWAIT  = 9'b000010000,
        S_SHRD   = 9'b000100000,
        S_SHWR   = 9'b001000000,
        S_INS    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic                 multi_reg;
    logic [NCNT_W-1:0]    node_cnt_reg, node_cnt_next;
    logic [ECNT_W-1:0]    edge_cnt_reg, edge_cnt_next;

    // latched item
    action_t              act_reg;
    logic [NODE_W-1:0]    src_reg, snk_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [DCNT_W-1:0]    deg_reg;

    // search registers: lo/hi in [0,deg]
    logic [DCNT_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic                 strict_reg, strict_next;
    logic [DCNT_W-1:0]    lb_reg, lb_next;
    logic [DCNT_W-1:0]    ptr_reg, ptr_next;

    // result registers
    logic [2:0]           st_reg, st_next;
    logic [DEG_W-1:0]     pos_reg, pos_next;
    logic [NODE_W-1:0]    nid_reg, nid_next;
    logic                 fnd_reg, fnd_next;
    logic [DIST_W-1:0]    fd_reg, fd_next;
    logic [DCNT_W-1:0]    od_reg, od_next;

    mem_req_t             req;
    logic [NODE_W-1:0]    rd_sink;
    logic [DIST_W-1:0]    rd_dist;

    logic [DCNT_W-1:0]    mid;
    logic [SLOT_W-1:0]    base;
    logic                 go_right;
    logic                 hit;
    logic                 deg_wr;

    // degree table port
    logic                 node_add;
    logic                 deg_wr_en;
    logic [NODE_W-1:0]    deg_wr_addr;
    logic [DCNT_W-1:0]    deg_wr_data;
    logic                 deg_rd_en;
    logic [DCNT_W-1:0]    rd_deg;

    sat_edge_mem u_mem (
        .aclk    (aclk),
        .req     (req),
        .rd_sink (rd_sink),
        .rd_dist (rd_dist)
    );

    // per-node out-degree, cleared when the node is added
    sat_ram #(.WIDTH(DCNT_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .aclk    (aclk),
        .wr_en   (deg_wr_en),
        .wr_addr (deg_wr_addr),
        .wr_data (deg_wr_data),
        .rd_en   (deg_rd_en),
        .rd_addr (s_source_node),
        .rd_data (rd_deg)
    );

    assign node_add    = (state_reg == S_IDLE) && s_valid &&
                         (action_t'(s_action) == ACT_ADD_NODE) &&
                         (node_cnt_reg < NCNT_W'(MAX_NODES));
    assign deg_wr_en   = node_add || deg_wr;
    assign deg_wr_addr = deg_wr ? src_reg : NODE_W'(node_cnt_reg);
    assign deg_wr_data = deg_wr ? (deg_reg + 1'b1) : '0;
    assign deg_rd_en   = (state_reg == S_IDLE) && s_valid;

    assign base     = SLOT_W'(src_reg) << DEG_W;
    assign mid      = DCNT_W'((lo_reg + hi_reg) >> 1);
    assign go_right = (rd_sink < snk_reg) || (strict_reg && (rd_sink == snk_reg));
    assign hit      = (lb_reg < deg_reg) && (rd_sink == snk_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    assign m_status         = st_reg;
    assign m_position       = pos_reg;
    assign m_new_node_id    = nid_reg;
    assign m_edge_found     = fnd_reg;
    assign m_found_distance = fd_reg;
    assign m_node_total     = node_cnt_reg;
    assign m_edge_total     = edge_cnt_reg;
    assign m_out_degree     = od_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        strict_next   = strict_reg;
        lb_next       = lb_reg;
        ptr_next      = ptr_reg;
        st_next       = st_reg;
        pos_next      = pos_reg;
        nid_next      = nid_reg;
        fnd_next      = fnd_reg;
        fd_next       = fd_reg;
        od_next       = od_reg;
        node_cnt_next = node_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        deg_wr        = 1'b0;
        req           = '0;
        req.wr_sink   = rd_sink;
        req.wr_dist   = rd_dist;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    st_next  = ST_OK;
                    pos_next = '0;
                    nid_next = '0;
                    fnd_next = 1'b0;
                    fd_next  = '0;
                    od_next  = '0;
                    lo_next  = '0;
                    strict_next = 1'b0;
                    if (action_t'(s_action) == ACT_ADD_NODE) begin
                        state_next = S_OUT;
                        if (node_cnt_reg >= NCNT_W'(MAX_NODES)) begin
                            st_next = ST_NODE_FULL;
                        end else begin
                            nid_next      = NODE_W'(node_cnt_reg);
                            node_cnt_next = node_cnt_reg + 1'b1;
                        end
                    end else if (NCNT_W'(s_source_node) >= node_cnt_reg ||
                                 NCNT_W'(s_sink_node) >= node_cnt_reg) begin
                        st_next    = ST_BAD_ID;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_HWAIT;
                    end
                end
            end
            S_HWAIT: begin
                // degree read returns here
                hi_next    = rd_deg;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = base + SLOT_W'(mid);
                    state_next  = S_SWAIT;
                end else begin
                    lb_next     = lo_reg;
                    req.rd_en   = 1'b1;
                    req.rd_addr = base + SLOT_W'(lo_reg[DEG_W-1:0]);
                    state_next  = strict_reg ? S_SHRD : S_DECIDE;
                    ptr_next    = deg_reg;
                end
            end
            S_SWAIT: begin
                if (go_right) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_DECIDE: begin
                // read data holds the entry at the lower bound
                if (act_reg == ACT_ADD_EDGE) begin
                    if (hit && !multi_reg) begin
                        pos_next   = lb_reg[DEG_W-1:0];
                        fnd_next   = 1'b1;
                        fd_next    = rd_dist;
                        od_next    = deg_reg;
                        state_next = S_OUT;
                    end else if (deg_reg >= DCNT_W'(MAX_DEGREE)) begin
                        st_next    = ST_LIST_FULL;
                        od_next    = deg_reg;
                        state_next = S_OUT;
                    end else if (hit) begin
                        fnd_next    = 1'b1;
                        fd_next     = rd_dist;
                        strict_next = 1'b1;
                        lo_next     = lb_reg;
                        hi_next     = deg_reg;
                        state_next  = S_SRCH;
                    end else begin
                        ptr_next   = deg_reg;
                        state_next = S_SHRD;
                    end
                end else if (!hit) begin
                    st_next    = ST_NOT_FOUND;
                    od_next    = deg_reg;
                    state_next = S_OUT;
                end else begin
                    pos_next   = lb_reg[DEG_W-1:0];
                    fnd_next   = 1'b1;
                    od_next    = deg_reg;
                    state_next = S_OUT;
                    if (act_reg == ACT_MODIFY) begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = base + SLOT_W'(lb_reg[DEG_W-1:0]);
                        req.wr_sink = rd_sink;
                        req.wr_dist = dist_reg;
                        fd_next     = dist_reg;
                    end else begin
                        fd_next = rd_dist;
                    end
                end
            end
            S_SHRD: begin
                // shift tail up one entry from the top down
                if (ptr_reg > lb_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = base + SLOT_W'(DEG_W'(ptr_reg - 1'b1));
                    state_next  = S_SHWR;
                end else begin
                    state_next = S_INS;
                end
            end
            S_SHWR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = base + SLOT_W'(ptr_reg[DEG_W-1:0]);
                ptr_next    = ptr_reg - 1'b1;
                state_next  = S_SHRD;
            end
            S_INS: begin
                req.wr_en     = 1'b1;
                req.wr_addr   = base + SLOT_W'(lb_reg[DEG_W-1:0]);
                req.wr_sink   = snk_reg;
                req.wr_dist   = dist_reg;
                deg_wr        = 1'b1;
                edge_cnt_next = edge_cnt_reg + 1'b1;
                pos_next      = lb_reg[DEG_W-1:0];
                od_next       = deg_reg + 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            multi_reg    <= 1'b0;
            node_cnt_reg <= '0;
            edge_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            node_cnt_reg <= node_cnt_next;
            edge_cnt_reg <= edge_cnt_next;
            if (cfg_wr_en) begin
                multi_reg <= cfg_wr_data;
            end
        end
    end

    // item and datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            act_reg  <= action_t'(s_action);
            src_reg  <= s_source_node;
            snk_reg  <= s_sink_node;
            dist_reg <= s_edge_distance;
        end
        if (state_reg == S_HWAIT) begin
            deg_reg <= rd_deg;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        strict_reg <= strict_next;
        lb_reg     <= lb_next;
        ptr_reg    <= ptr_next;
        st_reg     <= st_next;
        pos_reg    <= pos_next;
        nid_reg    <= nid_next;
        fnd_reg    <= fnd_next;
        fd_reg     <= fd_next;
        od_reg     <= od_next;
    end

`ifndef NO_ASSERTIONS
    // one item in flight: never ready while a result is shown
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");

    // edge count grows by at most one per cycle and only on insert
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (edge_cnt_reg != $past(edge_cnt_reg)) |-> $past(state_reg == S_INS))
        else $error("edge count changed outside insert");

    // a list-full result never changes the edge count
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_LIST_FULL) |-> $stable(edge_cnt_reg))
        else $error("edge count moved on full list");
`endif
endmodule
`default_nettype wire
